// ===== design/csvtok_pkg.sv =====
// Shared types for the CSV line token classifier: span record and push bundle.
`timescale 1ns / 1ps

package csvtok_pkg;

    localparam int START_W  = 12;
    localparam int LENGTH_W = 13;
    localparam int CLASS_W  = 3;
    localparam int COUNT_W  = 8;

    typedef struct packed {
        logic [START_W-1:0]  start;
        logic [LENGTH_W-1:0] length;
        logic [CLASS_W-1:0]  cls;
        logic                valid;
        logic                last;
        logic [COUNT_W-1:0]  count;
    } t_span;

    // Results produced by one accepted input beat: zero, one or two spans.
    typedef struct packed {
        logic [1:0] num;
        t_span      first;
        t_span      second;
    } t_push;

endpackage

// ===== design/csvtok_scan.sv =====
// Per-character scanner: line state registers and span close/open logic.
`timescale 1ns / 1ps

module csvtok_scan
    import csvtok_pkg::*;
#(
    parameter int MAX_TOKENS = 256,
    parameter int MAX_LINE   = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_beat,
    input  logic [7:0] i_char,
    input  logic       i_has_char,
    input  logic       i_eol,
    output t_push      o_push
);

    localparam int PW = $clog2(MAX_LINE + 1);
    localparam int CW = $clog2(MAX_TOKENS);
    localparam logic [PW-1:0] LINE_LIMIT = PW'(MAX_LINE);
    localparam logic [CW-1:0] SPAN_CAP   = CW'(MAX_TOKENS - 1);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [CLASS_W-1:0] CLS_TEXT    = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_PUNCT   = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_NUMBER  = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_STR     = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_CHAR    = 3'd4;
    localparam logic [CLASS_W-1:0] CLS_IDENT   = 3'd5;
    localparam logic [CLASS_W-1:0] CLS_KEYWORD = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_QUOTED,
        S_QPEND,
        S_UNQ,
        S_WS,
        S_SEP
    } t_mode;

    function automatic logic f_is_sep(input logic [7:0] c);
        return (c == CH_COMMA) || (c == CH_SEMI) || (c == CH_TAB) || (c == CH_BAR);
    endfunction

    function automatic logic f_is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic f_is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic f_is_field(input t_mode m);
        return (m == S_QUOTED) || (m == S_QPEND) || (m == S_UNQ);
    endfunction

    function automatic t_span f_close(
        input t_mode         m,
        input logic          par,
        input logic          num,
        input logic [PW-1:0] ts,
        input logic [PW-1:0] pos,
        input logic [CW-1:0] cnt,
        input logic          at_end
    );
        t_span s;
        case (m)
            S_QUOTED, S_QPEND: s.cls = par ? CLS_CHAR : CLS_STR;
            S_UNQ:             s.cls = num ? CLS_NUMBER : (par ? CLS_KEYWORD : CLS_IDENT);
            S_SEP:             s.cls = CLS_PUNCT;
            default:           s.cls = CLS_TEXT;
        endcase
        s.start  = START_W'(ts);
        s.length = LENGTH_W'(pos - ts);
        s.valid  = 1'b1;
        s.last   = at_end || (cnt >= SPAN_CAP);
        s.count  = COUNT_W'(cnt);
        return s;
    endfunction

    t_mode         r_mode, n_mode;
    logic [PW-1:0] r_pos, n_pos;
    logic [PW-1:0] r_tstart, n_tstart;
    logic          r_par, n_par;
    logic          r_dot, n_dot;
    logic          r_num, n_num;
    logic [CW-1:0] r_cnt, n_cnt;
    t_push         n_push;

    always_comb begin
        logic taken;
        logic do_close;
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_tstart = r_tstart;
        n_par    = r_par;
        n_dot    = r_dot;
        n_num    = r_num;
        n_cnt    = r_cnt;
        n_push   = '0;
        taken    = 1'b0;
        do_close = 1'b0;

        if (i_beat && i_has_char && (r_pos < LINE_LIMIT)) begin
            case (r_mode)
                S_QUOTED: begin
                    if (i_char == CH_QUOTE) begin
                        n_mode = S_QPEND;
                    end
                    taken = 1'b1;
                end
                S_QPEND: begin
                    if (i_char == CH_QUOTE) begin
                        n_mode = S_QUOTED;
                        taken  = 1'b1;
                    end else begin
                        do_close = 1'b1;
                    end
                end
                S_UNQ: begin
                    if (!f_is_sep(i_char) && !f_is_ws(i_char)) begin
                        if (i_char == CH_DOT) begin
                            if (r_dot) begin
                                n_num = 1'b0;
                            end
                            n_dot = 1'b1;
                        end else if (!f_is_digit(i_char)) begin
                            n_num = 1'b0;
                        end
                        taken = 1'b1;
                    end else begin
                        do_close = 1'b1;
                    end
                end
                S_WS: begin
                    if (f_is_ws(i_char) && (i_char != CH_TAB)) begin
                        taken = 1'b1;
                    end else begin
                        do_close = 1'b1;
                    end
                end
                S_SEP: begin
                    do_close = 1'b1;
                end
                default: begin
                end
            endcase

            if (do_close) begin
                n_cnt        = r_cnt + 1'b1;
                n_push.first = f_close(r_mode, r_par, r_num, r_tstart, r_pos, n_cnt, 1'b0);
                n_push.num   = 2'd1;
                n_par        = r_par ^ f_is_field(r_mode);
                n_mode       = S_IDLE;
            end

            if (!taken && (n_cnt < SPAN_CAP)) begin
                n_tstart = r_pos;
                if (i_char == CH_QUOTE) begin
                    n_mode = S_QUOTED;
                end else if (f_is_sep(i_char)) begin
                    n_mode = S_SEP;
                end else if (!f_is_ws(i_char)) begin
                    n_mode = S_UNQ;
                    n_dot  = (i_char == CH_DOT);
                    n_num  = f_is_digit(i_char) || (i_char == CH_DOT) ||
                             (i_char == CH_MINUS) || (i_char == CH_PLUS);
                end else begin
                    n_mode = S_WS;
                end
            end
            n_pos = r_pos + 1'b1;
        end

        if (i_beat && i_eol) begin
            // Close whatever is still open; an empty line yields one invalid span.
            if (n_mode != S_IDLE) begin
                if (n_push.num == 2'd0) begin
                    n_push.first = f_close(n_mode, n_par, n_num, n_tstart, n_pos,
                                           n_cnt + 1'b1, 1'b1);
                end else begin
                    n_push.second = f_close(n_mode, n_par, n_num, n_tstart, n_pos,
                                            n_cnt + 1'b1, 1'b1);
                end
                n_push.num = n_push.num + 2'd1;
            end else if (n_cnt == '0) begin
                n_push.first      = '0;
                n_push.first.last = 1'b1;
                n_push.num        = 2'd1;
            end
            n_mode   = S_IDLE;
            n_pos    = '0;
            n_tstart = '0;
            n_par    = 1'b0;
            n_dot    = 1'b0;
            n_num    = 1'b1;
            n_cnt    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= S_IDLE;
            r_pos    <= '0;
            r_tstart <= '0;
            r_par    <= 1'b0;
            r_dot    <= 1'b0;
            r_num    <= 1'b1;
            r_cnt    <= '0;
        end else begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_tstart <= n_tstart;
            r_par    <= n_par;
            r_dot    <= n_dot;
            r_num    <= n_num;
            r_cnt    <= n_cnt;
        end
    end

    assign o_push = n_push;

endmodule

// ===== design/csvtok_queue.sv =====
// Four-slot result queue: takes up to two spans a cycle, gives one a cycle while the receiver is ready.
`timescale 1ns / 1ps

module csvtok_queue
    import csvtok_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_room,
    output logic  o_valid,
    input  logic  i_ready,
    output t_span o_head
);

    localparam int DEPTH = 4;

    t_span      r_q [DEPTH];
    t_span      n_q [DEPTH];
    logic [2:0] r_count, n_count;
    logic [2:0] base;
    logic       pop;

    assign o_valid = (r_count != 3'd0);
    assign pop     = o_valid && i_ready;
    assign o_room  = (r_count <= 3'd2);
    assign o_head  = r_q[0];
    assign base    = r_count - {2'b0, pop};

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_q[i] = r_q[i];
            if (pop && (i < DEPTH - 1)) begin
                n_q[i] = r_q[i + 1];
            end
            if ((i_push.num != 2'd0) && (3'(i) == base)) begin
                n_q[i] = i_push.first;
            end
            if ((i_push.num == 2'd2) && (3'(i) == 3'(base + 3'd1))) begin
                n_q[i] = i_push.second;
            end
        end
        n_count = base + {1'b0, i_push.num};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 3'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

endmodule

// ===== design/csv_line_token_classifier.sv =====
// Top level of the CSV line token classifier: stream ports, scanner and result queue.
`timescale 1ns / 1ps

// One character of a line arrives per input beat, and the block takes a beat
// in every cycle while its result queue holds two spans or fewer. A span is
// closed by the character after it or by the end-of-line beat, so spans come
// out one beat late; a beat's results are registered in the queue behind any
// spans waiting there. A beat that both closes a span and ends the line gives
// two results; they wait in a four-slot queue and leave one per cycle while
// the receiver is ready, so the output side, not the scanner, sets the
// sustained rate on lines dense in such beats. Span classes: 0 whitespace,
// 1 separator (comma, semicolon, tab, bar), 2 number, 3/4 quoted field, 5/6
// plain field, the pair picked by a parity bit that flips after every field.
// A line with no spans gives one beat with the valid flag low. After
// MAX_TOKENS-1 spans the rest of the line is dropped; characters at position
// MAX_LINE and on are ignored. No clearing pass is needed after reset.

module csv_line_token_classifier
    import csvtok_pkg::*;
#(
    parameter int MAX_TOKENS = 256,
    parameter int MAX_LINE   = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic [0:0]  s_axis_tuser,   // [0] has_char
    input  logic        s_axis_tlast,   // end_of_line

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [11:0] span_start, [24:12] span_length,
                                        // [27:25] token_class, [35:28] span_count
    output logic [0:0]  m_axis_tuser,   // [0] span_valid
    output logic        m_axis_tlast    // is_last
);

    logic  beat;
    logic  room;
    t_push push;
    t_span head;

    // Input beat is taken whenever the queue can absorb two more spans.
    assign s_axis_tready = room;
    assign beat          = s_axis_tvalid && room;

    csvtok_scan #(
        .MAX_TOKENS (MAX_TOKENS),
        .MAX_LINE   (MAX_LINE)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_beat     (beat),
        .i_char     (s_axis_tdata),
        .i_has_char (s_axis_tuser[0]),
        .i_eol      (s_axis_tlast),
        .o_push     (push)
    );

    csvtok_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_head  (head)
    );

    assign m_axis_tdata = {4'b0, head.count, head.cls, head.length, head.start};
    assign m_axis_tuser = head.valid;
    assign m_axis_tlast = head.last;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking stream testbench for the CSV line token classifier.
`timescale 1ns / 1ps

module tb_top
    import csvtok_pkg::*;
();

    localparam int TOK_CAP  = 256;
    localparam int LINE_CAP = 4096;

    // Character codes that steer the scanner
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LOW_A = 8'h61;

    // Span classes
    localparam logic [2:0] CLS_TEXT    = 3'd0;
    localparam logic [2:0] CLS_PUNCT   = 3'd1;
    localparam logic [2:0] CLS_NUMBER  = 3'd2;
    localparam logic [2:0] CLS_STR     = 3'd3;
    localparam logic [2:0] CLS_CHAR    = 3'd4;
    localparam logic [2:0] CLS_IDENT   = 3'd5;
    localparam logic [2:0] CLS_KEYWORD = 3'd6;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_QUOTED,
        SCAN_QUOTE_SEEN,    // closing quote or first half of a doubled quote
        SCAN_FIELD,
        SCAN_BLANK,
        SCAN_SEP
    } t_scan_mode;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] char_code
    logic [0:0]  s_axis_tuser  = 1'b0;    // [0] has_char
    logic        s_axis_tlast  = 1'b0;    // end_of_line
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;            // [11:0] start, [24:12] length, [27:25] class,
                                          // [35:28] count
    logic [0:0]  m_axis_tuser;            // [0] span_valid
    logic        m_axis_tlast;            // is_last

    // Percentages of idle cycles on either side
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int err_count    = 0;

    // Spans predicted but not yet seen on the output, oldest first
    t_span pending_spans[$];

    // Scanner state mirrored by the predictor
    t_scan_mode  scan_mode;
    int unsigned char_pos;
    int unsigned tok_start;
    bit          parity;
    bit          seen_dot;
    bit          numeric;
    int unsigned spans_out;

    csv_line_token_classifier #(
        .MAX_TOKENS (TOK_CAP),
        .MAX_LINE   (LINE_CAP)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic bit is_sep(logic [7:0] c);
        return c == CH_COMMA || c == CH_SEMI || c == CH_TAB || c == CH_BAR;
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void clear_line();
        scan_mode = SCAN_IDLE;
        char_pos  = 0;
        tok_start = 0;
        parity    = 1'b0;
        seen_dot  = 1'b0;
        numeric   = 1'b1;
        spans_out = 0;
    endfunction

    // Close the open span at the current position and queue it
    function automatic void close_span(bit at_end);
        t_span s;
        logic [2:0] cls;
        case (scan_mode)
            SCAN_QUOTED, SCAN_QUOTE_SEEN: begin
                cls    = parity ? CLS_CHAR : CLS_STR;
                parity = !parity;
            end
            SCAN_FIELD: begin
                cls    = numeric ? CLS_NUMBER : (parity ? CLS_KEYWORD : CLS_IDENT);
                parity = !parity;
            end
            SCAN_SEP: cls = CLS_PUNCT;
            default:  cls = CLS_TEXT;
        endcase
        spans_out++;
        s.start  = tok_start[11:0];
        s.length = 13'(char_pos - tok_start);
        s.cls    = cls;
        s.valid  = 1'b1;
        s.last   = at_end || spans_out >= TOK_CAP - 1;
        s.count  = 8'(spans_out);
        pending_spans.push_back(s);
        scan_mode = SCAN_IDLE;
    endfunction

    function automatic void open_span(logic [7:0] c);
        tok_start = char_pos;
        if (c == CH_QUOTE) begin
            scan_mode = SCAN_QUOTED;
        end else if (is_sep(c)) begin
            scan_mode = SCAN_SEP;
        end else if (!is_blank(c)) begin
            scan_mode = SCAN_FIELD;
            seen_dot  = (c == CH_DOT);
            numeric   = is_digit(c) || c == CH_DOT || c == CH_MINUS || c == CH_PLUS;
        end else begin
            scan_mode = SCAN_BLANK;
        end
    endfunction

    // One accepted beat: take the character, then handle the end of line
    function automatic void scan_char(logic [7:0] c, bit has, bit eol);
        bit taken;
        t_span empty_line;
        taken = 1'b0;
        if (has && char_pos < LINE_CAP) begin
            case (scan_mode)
                SCAN_QUOTED: begin
                    if (c == CH_QUOTE)
                        scan_mode = SCAN_QUOTE_SEEN;
                    taken = 1'b1;
                end
                SCAN_QUOTE_SEEN: begin
                    if (c == CH_QUOTE) begin
                        scan_mode = SCAN_QUOTED;
                        taken     = 1'b1;
                    end else begin
                        close_span(1'b0);
                    end
                end
                SCAN_FIELD: begin
                    if (!is_sep(c) && !is_blank(c)) begin
                        if (c == CH_DOT) begin
                            if (seen_dot)
                                numeric = 1'b0;
                            seen_dot = 1'b1;
                        end else if (!is_digit(c)) begin
                            numeric = 1'b0;
                        end
                        taken = 1'b1;
                    end else begin
                        close_span(1'b0);
                    end
                end
                SCAN_BLANK: begin
                    if (is_blank(c) && c != CH_TAB)
                        taken = 1'b1;
                    else
                        close_span(1'b0);
                end
                SCAN_SEP: close_span(1'b0);
                default: ;
            endcase
            // past the span cap the rest of the line is dropped
            if (!taken && spans_out < TOK_CAP - 1)
                open_span(c);
            char_pos++;
        end
        if (eol) begin
            if (scan_mode != SCAN_IDLE) begin
                close_span(1'b1);
            end else if (spans_out == 0) begin
                empty_line      = '0;
                empty_line.last = 1'b1;
                pending_spans.push_back(empty_line);
            end
            clear_line();
        end
    endfunction

    // ---------------------------------------------------------------- checker

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge i_clk) begin : check_spans
        t_span oldest;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_spans.size() == 0) begin
                $display("%0t ns: unexpected span beat, expected none, actual tdata %h",
                         $time, m_axis_tdata);
                err_count++;
            end else begin
                oldest = pending_spans.pop_front();
                check_field("span_start",  oldest.start,  m_axis_tdata[11:0]);
                check_field("span_length", oldest.length, m_axis_tdata[24:12]);
                check_field("token_class", oldest.cls,    m_axis_tdata[27:25]);
                check_field("span_count",  oldest.count,  m_axis_tdata[35:28]);
                check_field("tdata pad",   0,             m_axis_tdata[39:36]);
                check_field("span_valid",  oldest.valid,  m_axis_tuser[0]);
                check_field("is_last",     oldest.last,   m_axis_tlast);
            end
        end
    end

    // Receiver back-pressure
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);

    // ---------------------------------------------------------------- stimulus

    task automatic send_beat(input logic [7:0] c, input bit has, input bit eol);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= has;
        s_axis_tlast  <= eol;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        scan_char(c, has, eol);
    endtask

    // Send a line; either the last character carries the end flag or a bare
    // end marker follows. Bare markers mid-line are sprinkled at marker_pct.
    task automatic send_line(input logic [7:0] chars[$], input bit eol_on_char,
                             input int marker_pct);
        int n;
        n = chars.size();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < marker_pct)
                send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
            send_beat(chars[i], 1'b1, eol_on_char && i == n - 1);
        end
        if (!eol_on_char || n == 0)
            send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    // Sender goes quiet until every predicted span has come out
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_spans.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);   // beats that end in no span may still be in flight
    endtask

    function automatic void append_text(ref logic [7:0] q[$], input string txt);
        for (int i = 0; i < txt.len(); i++)
            q.push_back(txt[i]);
    endfunction

    function automatic logic [7:0] pick_sep();
        case ($urandom_range(3))
            0:       return CH_COMMA;
            1:       return CH_SEMI;
            2:       return CH_TAB;
            default: return CH_BAR;
        endcase
    endfunction

    // Mostly well-formed CSV with random content, plus some raw noise
    function automatic void gen_line(ref logic [7:0] q[$]);
        int n_tok;
        int len;
        q = {};
        if ($urandom_range(99) < 8)
            return;
        n_tok = $urandom_range(1, 10);
        for (int t = 0; t < n_tok; t++) begin
            len = $urandom_range(1, 6);
            case ($urandom_range(7))
                0, 1: begin
                    if ($urandom_range(2) == 0)
                        q.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
                    for (int i = 0; i < len; i++)
                        q.push_back(($urandom_range(5) == 0) ? CH_DOT
                                                             : 8'(CH_ZERO + $urandom_range(9)));
                end
                2, 3: begin
                    for (int i = 0; i < len; i++) begin
                        case ($urandom_range(5))
                            0:       q.push_back(8'(CH_ZERO + $urandom_range(9)));
                            1:       q.push_back(8'($urandom_range(128, 255)));
                            default: q.push_back(8'(CH_LOW_A + $urandom_range(25)));
                        endcase
                    end
                end
                4: begin
                    q.push_back(CH_QUOTE);
                    for (int i = 0; i < len - 1; i++) begin
                        case ($urandom_range(5))
                            0: begin
                                q.push_back(CH_QUOTE);
                                q.push_back(CH_QUOTE);
                            end
                            1:       q.push_back(pick_sep());
                            2:       q.push_back(CH_SPACE);
                            default: q.push_back(8'(CH_LOW_A + $urandom_range(25)));
                        endcase
                    end
                    if ($urandom_range(9) != 0)
                        q.push_back(CH_QUOTE);
                end
                5: q.push_back(pick_sep());
                6: begin
                    for (int i = 0; i < (len + 1) / 2; i++)
                        q.push_back(($urandom_range(1) == 0) ? CH_SPACE
                                                             : 8'($urandom_range(CH_LF, CH_CR)));
                end
                default: begin
                    for (int i = 0; i < (len + 1) / 2; i++)
                        q.push_back(8'($urandom_range(255)));
                end
            endcase
            if ($urandom_range(99) < 60)
                q.push_back(pick_sep());
        end
    endfunction

    // ---------------------------------------------------------------- tests

    // Empty lines: a bare end marker, and one after a marker without character
    task automatic test_empty_lines();
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'hFF, 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
    endtask

    // Every span class, doubled-quote escape, extreme codes, a two-span end
    // beat, an unterminated quote and a quote closed by the end of line
    task automatic test_field_kinds();
        logic [7:0] line_buf[$];
        append_text(line_buf, "\"a\"\"b\",-1.5;x");
        line_buf.push_back(8'hFF);
        line_buf.push_back(8'h00);
        append_text(line_buf, "|\t 1.. +");
        send_line(line_buf, 1'b1, 0);
        line_buf = {};
        append_text(line_buf, "x,\"a");
        send_line(line_buf, 1'b0, 0);
        line_buf = {};
        append_text(line_buf, "\"q\"");
        send_line(line_buf, 1'b1, 0);
        drain_results();
    endtask

    // Span cap: alternating field and comma until the cap is hit mid-line
    task automatic test_span_cap();
        logic [7:0] line_buf[$];
        repeat (130) begin
            line_buf.push_back(CH_LOW_A);
            line_buf.push_back(CH_COMMA);
        end
        send_line(line_buf, 1'b0, 0);
        line_buf = {};
        append_text(line_buf, "7;");
        send_line(line_buf, 1'b1, 0);
        drain_results();
    endtask

    task automatic test_random_lines(input int n_chars, input int idle_pct,
                                     input int stall_pct);
        logic [7:0] line_buf[$];
        int sent;
        tx_idle_pct  = idle_pct;
        rx_stall_pct = stall_pct;
        sent         = 0;
        while (sent < n_chars) begin
            gen_line(line_buf);
            send_line(line_buf, 1'(($urandom_range(1))), 5);
            sent += line_buf.size();
        end
        drain_results();
    endtask

    initial begin
        clear_line();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_lines();
        test_field_kinds();
        tx_idle_pct  = 20;
        rx_stall_pct = 20;
        test_span_cap();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;

        test_random_lines(225, 0, 0);
        test_random_lines(225, 65, 0);
        test_random_lines(225, 0, 65);
        test_random_lines(225, 20, 20);

        while (pending_spans.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
